>>> rtl/assert_macros.svh
// Assertion macros for the RTL files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/bsc_pkg.sv
// Shared constants, types and helper functions of the safety checker.
package bsc_pkg;

	localparam int MAX_PROCESSES = 8;
	localparam int MAX_RESOURCES = 4;

	localparam int PROC_W    = $clog2(MAX_PROCESSES);
	localparam int RES_W     = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
	localparam int CNT_W     = $clog2(MAX_PROCESSES + 1);
	localparam int TBL_AW    = PROC_W + RES_W;
	localparam int TBL_DEPTH = MAX_PROCESSES * MAX_RESOURCES;

	localparam int OP_W   = 2;
	localparam int PIDX_W = 3;
	localparam int RIDX_W = 2;
	localparam int AMT_W  = 8;
	localparam int WORK_W = 16;

	localparam int PCFG_W  = 4;
	localparam int RCFG_W  = 3;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [PCFG_W-1:0] PROCS_RESET = PCFG_W'(5);
	localparam logic [RCFG_W-1:0] RES_RESET   = RCFG_W'(3);

	// register numbers on the configuration port
	localparam logic REG_PROCS = 1'b0;
	localparam logic REG_RES   = 1'b1;

	// operation codes of a command item
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_CLAIM = 2'd1;
	localparam logic [OP_W-1:0] OP_AVAIL = 2'd2;
	localparam logic [OP_W-1:0] OP_RUN   = 2'd3;

	typedef struct packed {
		logic              alloc_we;
		logic              claim_we;
		logic [TBL_AW-1:0] addr;
		logic [AMT_W-1:0]  data;
	} tbl_wr_t;

	typedef struct packed {
		logic [AMT_W-1:0] alloc;
		logic [AMT_W-1:0] claim;
	} tbl_rd_t;

	typedef struct packed {
		logic [PROC_W-1:0] np_m1;
		logic [RES_W-1:0]  nr_m1;
	} run_cfg_t;

	// last process number in use: zero counts as one, clamp to the table depth
	function automatic logic [PROC_W-1:0] procs_m1(input logic [PCFG_W-1:0] v);
		logic [PROC_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (int'(v) > MAX_PROCESSES) begin
			r = PROC_W'(MAX_PROCESSES - 1);
		end else begin
			r = PROC_W'(v - 1'b1);
		end
		return r;
	endfunction

	// last resource number in use: zero counts as one, clamp to the table width
	function automatic logic [RES_W-1:0] res_m1(input logic [RCFG_W-1:0] v);
		logic [RES_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (int'(v) > MAX_RESOURCES) begin
			r = RES_W'(MAX_RESOURCES - 1);
		end else begin
			r = RES_W'(v - 1'b1);
		end
		return r;
	endfunction

endpackage

>>> rtl/bsc_if.sv
// Valid/ready channel interfaces for command items and result items.
interface bsc_cmd_if import bsc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [PIDX_W-1:0] process_index;
	logic [RIDX_W-1:0] resource_index;
	logic [AMT_W-1:0]  amount;

	modport source (output valid, output operation, output process_index,
		output resource_index, output amount, input ready);
	modport sink (input valid, input operation, input process_index,
		input resource_index, input amount, output ready);
endinterface

interface bsc_res_if import bsc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              safe;
	logic [PIDX_W-1:0] process_id;
	logic              last;

	modport source (output valid, output safe, output process_id, output last,
		input ready);
	modport sink (input valid, input safe, input process_id, input last,
		output ready);
endinterface

>>> rtl/bsc_table_mem.sv
// Allocation and claim tables: one write port, one registered read port each.
module bsc_table_mem import bsc_pkg::*; (
	input  logic              clk,
	input  tbl_wr_t           wr,
	input  logic              rd_en,
	input  logic [TBL_AW-1:0] rd_addr,
	output tbl_rd_t           rd
);

	logic [AMT_W-1:0] alloc_mem [TBL_DEPTH];
	logic [AMT_W-1:0] claim_mem [TBL_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.alloc_we) begin
			alloc_mem[wr.addr] <= wr.data;
		end
		if (wr.claim_we) begin
			claim_mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd.alloc <= alloc_mem[rd_addr];
			rd.claim <= claim_mem[rd_addr];
		end
	end

endmodule

>>> rtl/bsc_seq.sv
// Run sequencer: scans the tables, tracks working counts, emits the order.
module bsc_seq import bsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  run_cfg_t          cfg,
	bsc_cmd_if.sink           cmd,
	bsc_res_if.source         res,
	output tbl_wr_t           tbl_wr,
	output logic              tbl_rd_en,
	output logic [TBL_AW-1:0] tbl_rd_addr,
	input  tbl_rd_t           tbl_rd,
	output logic              busy
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_CHK    = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;

	logic [2:0]         state_q;
	logic [PROC_W-1:0]  j_q;
	logic [PROC_W-1:0]  pass_q;
	logic [PROC_W-1:0]  k_q;
	logic [RES_W-1:0]   ri_q;
	logic               fit_q;
	logic               rvalid_s1;
	logic [RES_W-1:0]   rres_s1;
	logic [CNT_W-1:0]   count_q;
	logic [AMT_W-1:0]   avail_q [MAX_RESOURCES];
	logic [AMT_W-1:0]   row_q   [MAX_RESOURCES];
	logic [WORK_W-1:0]  work_q  [MAX_RESOURCES];
	logic [PROC_W-1:0]  order_q [MAX_PROCESSES];
	logic [MAX_PROCESSES-1:0] fin_q;

	logic               out_valid_q;
	logic               out_safe_q;
	logic [PIDX_W-1:0]  out_id_q;
	logic               out_last_q;

	logic               accept;
	logic               cur_ok;
	logic               fit_now;
	logic               last_j;
	logic               last_pass;
	logic               out_load;
	logic               unsafe;
	logic [CNT_W-1:0]   np_cnt;
	logic [AMT_W-1:0]   alloc_row [MAX_RESOURCES];
	logic [WORK_W-1:0]  work_sat  [MAX_RESOURCES];
	logic [WORK_W:0]    work_sum  [MAX_RESOURCES];
	logic [AMT_W-1:0]   need;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);

	// table loads go straight to the memories
	assign tbl_wr.alloc_we = accept && (cmd.operation == OP_ALLOC);
	assign tbl_wr.claim_we = accept && (cmd.operation == OP_CLAIM);
	assign tbl_wr.addr     = {cmd.process_index[PROC_W-1:0], cmd.resource_index[RES_W-1:0]};
	assign tbl_wr.data     = cmd.amount;

	assign tbl_rd_en   = (state_q == ST_CHK);
	assign tbl_rd_addr = {j_q, ri_q};

	// need check on the entry returned this cycle
	assign need    = tbl_rd.claim - tbl_rd.alloc;
	assign cur_ok  = !((tbl_rd.claim > tbl_rd.alloc) &&
		(WORK_W'(need) > work_q[rres_s1]));
	assign fit_now = fit_q && (!rvalid_s1 || cur_ok);

	always_comb begin
		for (int r = 0; r < MAX_RESOURCES; r++) begin
			alloc_row[r] = (rvalid_s1 && (rres_s1 == RES_W'(r))) ? tbl_rd.alloc : row_q[r];
			work_sum[r]  = {1'b0, work_q[r]} + (WORK_W+1)'(alloc_row[r]);
			work_sat[r]  = work_sum[r][WORK_W] ? '1 : work_sum[r][WORK_W-1:0];
		end
	end

	assign last_j    = (j_q == cfg.np_m1);
	assign last_pass = (pass_q == cfg.np_m1);
	assign np_cnt    = CNT_W'(cfg.np_m1) + 1'b1;
	assign unsafe    = (count_q < np_cnt);
	assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			j_q         <= '0;
			pass_q      <= '0;
			k_q         <= '0;
			ri_q        <= '0;
			fit_q       <= 1'b0;
			rvalid_s1   <= 1'b0;
			rres_s1     <= '0;
			count_q     <= '0;
			fin_q       <= '0;
			out_valid_q <= 1'b0;
			for (int r = 0; r < MAX_RESOURCES; r++) begin
				work_q[r] <= '0;
			end
			for (int p = 0; p < MAX_PROCESSES; p++) begin
				order_q[p] <= '0;
			end
		end else begin
			rvalid_s1 <= (state_q == ST_CHK);
			rres_s1   <= ri_q;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && (cmd.operation == OP_RUN)) begin
						for (int r = 0; r < MAX_RESOURCES; r++) begin
							work_q[r] <= (RES_W'(r) <= cfg.nr_m1) ? WORK_W'(avail_q[r]) : '0;
						end
						for (int p = 0; p < MAX_PROCESSES; p++) begin
							order_q[p] <= '0;
						end
						fin_q   <= '0;
						count_q <= '0;
						j_q     <= '0;
						pass_q  <= '0;
						k_q     <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (fin_q[j_q]) begin
						if (last_j) begin
							j_q <= '0;
							if (last_pass) begin
								state_q <= ST_EMIT;
							end else begin
								pass_q <= pass_q + 1'b1;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						ri_q    <= '0;
						fit_q   <= 1'b1;
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					fit_q <= fit_now;
					if (ri_q == cfg.nr_m1) begin
						state_q <= ST_DECIDE;
					end else begin
						ri_q <= ri_q + 1'b1;
					end
				end
				ST_DECIDE: begin
					if (fit_now) begin
						fin_q[j_q]                         <= 1'b1;
						order_q[count_q[PROC_W-1:0]]       <= j_q;
						count_q                            <= count_q + 1'b1;
						for (int r = 0; r < MAX_RESOURCES; r++) begin
							if (RES_W'(r) <= cfg.nr_m1) begin
								work_q[r] <= work_sat[r];
							end
						end
					end
					if (last_j) begin
						j_q <= '0;
						if (last_pass) begin
							state_q <= ST_EMIT;
						end else begin
							pass_q  <= pass_q + 1'b1;
							state_q <= ST_SCAN;
						end
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (unsafe || (k_q == cfg.np_m1)) begin
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// capture the available vector and the allocation row of the process under test
	always_ff @(posedge clk) begin
		if (accept && (cmd.operation == OP_AVAIL)) begin
			avail_q[cmd.resource_index[RES_W-1:0]] <= cmd.amount;
		end
		if (rvalid_s1) begin
			row_q[rres_s1] <= tbl_rd.alloc;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_safe_q <= !unsafe;
			out_id_q   <= unsafe ? '0 : PIDX_W'(order_q[k_q]);
			out_last_q <= unsafe || (k_q == cfg.np_m1);
		end
	end

	assign res.valid      = out_valid_q;
	assign res.safe       = out_safe_q;
	assign res.process_id = out_id_q;
	assign res.last       = out_last_q;

endmodule

>>> rtl/bankers_safety_check.sv
// Top level of the banker's safety checker: configuration port and core.
//
// cmd carries command items (valid/ready). Operations write one entry of the
// allocation table, the claim table or the available vector, or run the
// safety check. A load gives no result and can follow another load every
// cycle while no run is in progress.
// A run copies the available vector into working counts and makes one pass
// per process in use. In a pass an unfinished process goes through scan,
// one table read per resource and decide, and a finished one only through
// scan; the single read port of the table memory makes the reads one per
// resource. When the passes are done, results leave the output register
// one result per cycle while res.ready is high.
// res carries result items through an output register: the safe order one
// process per item, last set on the final one, or a single item with safe low.
// cmd.ready is low for the whole run and returns high while the final result
// may still wait. When res.ready is low the output register holds its item
// and the run holds in its emit step.
// Reset clears the sequencer and sets processes_in_use to 5 and
// resources_in_use to 3; table contents are undefined until written. APB
// registers lie at byte 0 (processes) and 4 (resources); write them when idle.
module bankers_safety_check import bsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	bsc_cmd_if.sink            cmd,
	bsc_res_if.source          res
);

`include "assert_macros.svh"

	logic [PCFG_W-1:0] procs_q;
	logic [RCFG_W-1:0] res_q;
	logic              cfg_we;
	logic              reg_sel;
	run_cfg_t          run_cfg;
	tbl_wr_t           tbl_wr;
	tbl_rd_t           tbl_rd;
	logic              tbl_rd_en;
	logic [TBL_AW-1:0] tbl_rd_addr;
	logic              busy;

	// APB: no wait states; decode the register by the word address bit
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			procs_q <= PROCS_RESET;
			res_q   <= RES_RESET;
		end else if (cfg_we) begin
			if (reg_sel == REG_PROCS) begin
				procs_q <= pwdata[PCFG_W-1:0];
			end else begin
				res_q <= pwdata[RCFG_W-1:0];
			end
		end
	end

	assign prdata = (reg_sel == REG_PROCS) ? PDATA_W'(procs_q) : PDATA_W'(res_q);

	// Clamp the counts once here so the sequencer sees last indexes only
	assign run_cfg.np_m1 = procs_m1(procs_q);
	assign run_cfg.nr_m1 = res_m1(res_q);

	bsc_table_mem u_mem (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd_en   (tbl_rd_en),
		.rd_addr (tbl_rd_addr),
		.rd      (tbl_rd)
	);

	bsc_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (run_cfg),
		.cmd         (cmd),
		.res         (res),
		.tbl_wr      (tbl_wr),
		.tbl_rd_en   (tbl_rd_en),
		.tbl_rd_addr (tbl_rd_addr),
		.tbl_rd      (tbl_rd),
		.busy        (busy)
	);

	// An unsafe verdict is a lone item with process 0
	`ASSERT_IMPL(a_unsafe_shape, clk, arst_n, res.valid && !res.safe, (res.process_id == '0) && res.last)
	// Hold off commands for the whole run, so the tables never change under a scan
	`ASSERT_IMPL(a_busy_blocks, clk, arst_n, busy, !cmd.ready)
	// Start the scan right after a run item is taken
	`ASSERT_NEXT(a_run_starts, clk, arst_n, cmd.valid && cmd.ready && (cmd.operation == OP_RUN), busy)

endmodule
